// ===== hw/rtl/rbsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_pkg: shared types and constants for the ROM bank slot cache
// Field widths of the request and result words and the per-cell control group.
// ----------------------------------------------------------------------------
package rbsc_pkg;

  localparam int BANK_W       = 9;
  localparam int SLOT_FIELD_W = 3;

  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

  // Control broadcast to every cell of the slot row
  typedef struct packed {
    logic cmp;     // latch tag compare against the request bank
    logic commit;  // miss: tag the token cell and pass the token on
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/rbsc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_cell: one cache slot
// Holds a tag, a valid bit and one bit of the round-robin replace token.
// The token moves to the next cell on every miss.
// ----------------------------------------------------------------------------
module rbsc_cell #(
  parameter logic TOKEN_INIT = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rbsc_pkg::cell_ctrl_t ctrl,
  input  rbsc_pkg::bank_t     bank,
  input  logic                token_in,
  output logic                token,
  output logic                match
);

  rbsc_pkg::bank_t tag_r;
  logic            valid_r;
  logic            token_r;
  logic            match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      token_r <= TOKEN_INIT;
    end else begin
      if (ctrl.commit) begin
        if (token_r) begin
          tag_r   <= bank;
          valid_r <= 1'b1;
        end
        // advance the replace token one cell along the ring
        token_r <= token_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match_r <= valid_r && (tag_r == bank);
    end
  end

  assign token = token_r;
  assign match = match_r;

endmodule

// ===== hw/rtl/rom_bank_slot_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_slot_cache_unit: fully associative ROM bank slot cache
// Maps a requested bank to a slot; misses take the slot under a round-robin
// token that circulates through a ring of slot cells.
//
//   channel  direction  handshake            word
//   in_      request    in_valid / in_stall  in_bank
//   out_     result     out_valid / out_stall out_skipped, out_hit, out_slot,
//                                            out_load_needed
//   cfg_     register   cfg_valid / cfg_ready cfg_skip_repeat
//
// Per request, the accepting edge latches every cell's tag compare; in S_RES
// the match row is encoded and written to the result register once the
// output register is free. A finished result waits in the output register
// while the next request is taken; a stalled result holds the unit in S_RES.
// Reset clears valid bits, puts the token on slot 0, sets skip_repeat.
// ----------------------------------------------------------------------------
module rom_bank_slot_cache_unit #(
  parameter int SLOTS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rbsc_pkg::bank_t         in_bank,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_skipped,
  output logic                    out_hit,
  output rbsc_pkg::slot_field_t   out_slot,
  output logic                    out_load_needed,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_skip_repeat
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_RES
  } state_t;

  state_t                state_r;
  rbsc_pkg::bank_t       bank_r;
  rbsc_pkg::bank_t       prev_r;
  logic                  skip_r;
  logic                  skip_en_r;
  logic                  out_valid_r;
  logic                  out_skipped_r;
  logic                  out_hit_r;
  rbsc_pkg::slot_field_t out_slot_r;
  logic                  out_load_needed_r;

  logic [SLOTS-1:0]      match_vec;
  logic [SLOTS-1:0]      token_vec;
  logic [SLOTS-1:0]      sel_vec;
  logic [SLOT_W-1:0]     sel_idx;
  logic [SLOT_W+2:0]     sel_ext;
  rbsc_pkg::bank_t       cell_bank;
  rbsc_pkg::cell_ctrl_t  ctrl;
  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic                  hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_RES) && out_free;
  assign hit      = |match_vec;

  assign ctrl.cmp    = accept;
  assign ctrl.commit = commit && !skip_r && !hit;
  // compare against the incoming word, write with the held one
  assign cell_bank   = accept ? in_bank : bank_r;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      rbsc_cell #(
        .TOKEN_INIT ((g == 0) ? 1'b1 : 1'b0)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .bank     (cell_bank),
        .token_in (token_vec[(g + SLOTS - 1) % SLOTS]),
        .token    (token_vec[g]),
        .match    (match_vec[g])
      );
    end
  endgenerate

  // lowest matching slot on a hit, token slot on a miss
  assign sel_vec = hit ? match_vec : token_vec;

  always_comb begin
    sel_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (sel_vec[i]) begin
        sel_idx = SLOT_W'(i);
      end
    end
  end

  assign sel_ext = {3'b000, sel_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      skip_en_r   <= 1'b1;
      prev_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        skip_en_r <= cfg_skip_repeat;
      end
      // drop the taken word unless a new one replaces it this edge
      if (out_valid_r && !out_stall && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            bank_r  <= in_bank;
            skip_r  <= skip_en_r && (in_bank == prev_r);
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_skipped_r     <= skip_r;
            out_hit_r         <= !skip_r && hit;
            out_slot_r        <= skip_r ? '0 : sel_ext[2:0];
            out_load_needed_r <= !skip_r && !hit;
            if (!skip_r) begin
              prev_r <= bank_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_skipped     = out_skipped_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_load_needed = out_load_needed_r;

endmodule
